// File: sv/spid_pkg.sv
// ----------------------------------------------------------------------------
// spid_pkg
// Types and register indexes shared by the sampled PID controller and its
// checker.
// ----------------------------------------------------------------------------
package spid_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROPORTIONAL_GAIN = 2'd0,
        CFG_INTEGRAL_GAIN     = 2'd1,
        CFG_DERIVATIVE_GAIN   = 2'd2,
        CFG_SAMPLE_PERIOD_MS  = 2'd3
    } t_cfg_idx;

    localparam logic [15:0] SAMPLE_PERIOD_RESET = 16'd10;

    typedef struct packed {
        logic        [31:0] time_ms;
        logic signed [15:0] setpoint;
        logic signed [15:0] measurement;
    } t_pid_in;

    typedef struct packed {
        logic               updated;
        logic signed [31:0] drive;
    } t_pid_out;

endpackage

// File: sv/sampled_pid_controller.sv
// ----------------------------------------------------------------------------
// sampled_pid_controller
// Discrete PID controller with a sample-period gate on a wrapping ms clock.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is registered at the input, then passes through
// the gate, multiply and summing stages, each of them registered.
// Throughput: one item per cycle; the period gate and the controller state
// update close in the gate stage, so items follow back to back unless stalled.
// Reset: synchronous active-low i_rst_n empties the pipeline, clears the
// controller state and gains, and sets the sample period to 10 ms.
// ----------------------------------------------------------------------------
module sampled_pid_controller import spid_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_pid_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_pid_out              o_out_data
);

    // Configuration registers.
    logic signed [31:0] r_kp, r_ki, r_kd;
    logic        [15:0] r_period;

    // Controller state.
    logic        [31:0] r_last_time;
    logic               r_primed;
    logic signed [16:0] r_prev_err;
    logic signed [31:0] r_err_sum;
    logic signed [31:0] r_held;

    // Pipeline valids and payloads.
    logic               r_v0, r_v1, r_v2, r_v3;
    t_pid_in            r_in0;
    logic               r_go1, r_go2;
    logic signed [16:0] r_e1;
    logic signed [17:0] r_diff1;
    logic signed [31:0] r_sum1;
    logic signed [48:0] r_pp2;
    logic signed [49:0] r_pd2;
    logic signed [63:0] r_pi2;
    t_pid_out           r_out3;

    logic rdy1, rdy2, rdy3;
    logic en1;

    logic        [31:0] n_elapsed;
    logic               n_go;
    logic signed [16:0] n_e;
    logic signed [32:0] n_sum_wide;
    logic signed [31:0] n_sum;
    logic signed [17:0] n_diff;
    logic signed [48:0] n_pp;
    logic signed [49:0] n_pd;
    logic signed [63:0] n_pi;
    logic signed [63:0] n_acc;
    logic signed [47:0] n_shift;
    logic signed [31:0] n_drive;
    t_pid_out           n_out;

    assign rdy3       = !r_v3 || i_out_ready;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = !r_v0 || rdy1;
    assign en1        = r_v0 && rdy1;

    // Stage 1: period gate, error, saturating sum and error difference.
    always_comb begin
        n_elapsed  = r_in0.time_ms - r_last_time;
        n_go       = !r_primed || (n_elapsed >= {16'd0, r_period});
        n_e        = {r_in0.setpoint[15], r_in0.setpoint}
                   - {r_in0.measurement[15], r_in0.measurement};
        n_sum_wide = {r_err_sum[31], r_err_sum} + {{16{n_e[16]}}, n_e};
        if (n_sum_wide[32] != n_sum_wide[31]) begin
            n_sum = n_sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_sum = n_sum_wide[31:0];
        end
        n_diff = {n_e[16], n_e} - {r_prev_err[16], r_prev_err};
    end

    // Stage 2: the three gain products.
    always_comb begin
        n_pp = r_kp * r_e1;
        n_pd = r_kd * r_diff1;
        n_pi = r_ki * r_sum1;
    end

    // Stage 3: sum, floor shift by 16 and saturation.
    always_comb begin
        n_acc   = {{15{r_pp2[48]}}, r_pp2} + {{14{r_pd2[49]}}, r_pd2} + r_pi2;
        n_shift = n_acc[63:16];
        if (n_shift[47:31] != {17{n_shift[47]}}) begin
            n_drive = n_shift[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            n_drive = n_shift[31:0];
        end
        n_out.updated = r_go2;
        n_out.drive   = r_go2 ? n_drive : r_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= '0;
            r_ki        <= '0;
            r_kd        <= '0;
            r_period    <= SAMPLE_PERIOD_RESET;
            r_last_time <= '0;
            r_primed    <= 1'b0;
            r_prev_err  <= '0;
            r_err_sum   <= '0;
            r_held      <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PROPORTIONAL_GAIN: r_kp     <= i_cfg_data;
                    CFG_INTEGRAL_GAIN:     r_ki     <= i_cfg_data;
                    CFG_DERIVATIVE_GAIN:   r_kd     <= i_cfg_data;
                    CFG_SAMPLE_PERIOD_MS:  r_period <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_v0 <= i_in_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            // State that the next item's gate depends on moves at stage 1.
            if (en1 && n_go) begin
                r_last_time <= r_in0.time_ms;
                r_primed    <= 1'b1;
                r_prev_err  <= n_e;
                r_err_sum   <= n_sum;
            end
            // The held drive follows the items in order at stage 3.
            if (r_v2 && rdy3 && r_go2) begin
                r_held <= n_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in0 <= i_in_data;
        end
        if (rdy1) begin
            r_go1   <= n_go;
            r_e1    <= n_e;
            r_diff1 <= n_diff;
            r_sum1  <= n_sum;
        end
        if (rdy2) begin
            r_go2 <= r_go1;
            r_pp2 <= n_pp;
            r_pd2 <= n_pd;
            r_pi2 <= n_pi;
        end
        if (rdy3) begin
            r_out3 <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out3;

endmodule

// File: sv/spid_checker.sv
// ----------------------------------------------------------------------------
// spid_checker
// Port-level assertions for the sampled PID controller, bound to its top.
// ----------------------------------------------------------------------------
module spid_checker import spid_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_pid_out o_out_data
);

    logic               r_seen;
    logic signed [31:0] r_last_drive;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen       <= 1'b0;
            r_last_drive <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_seen       <= 1'b1;
            r_last_drive <= o_out_data.drive;
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result valid dropped before the item was taken");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_first_updates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_seen |-> o_out_data.updated)
        else $error("first result after reset did not update");

    a_drive_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.updated |-> o_out_data.drive == r_last_drive)
        else $error("drive not held on a result without update");

endmodule

bind sampled_pid_controller spid_checker u_spid_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sampled PID controller. Samples are driven on
// a valid/ready input channel with random gaps. A class-based predictor
// tracks the sample-period gate, the saturating error sum and the drive
// from the Q16.16 gains. Every result is compared against the oldest
// predicted result. The run covers directed corner cases, several random
// gain and period settings, and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import spid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RESULT_LATENCY = 3;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int unsigned PHASE_ITEMS    = 66;

    localparam logic [15:0] CORNERS [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    class pid_drive_checker;
        logic signed [31:0] kp;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic        [15:0] period;
        logic        [31:0] last_time;
        bit                 primed;
        longint             prev_err;
        longint             err_sum;
        longint             held_drive;
        t_pid_out           pending_drives[$];
        int unsigned        fail_count;

        function new();
            kp         = '0;
            ki         = '0;
            kd         = '0;
            period     = SAMPLE_PERIOD_RESET;
            last_time  = '0;
            primed     = 1'b0;
            prev_err   = 0;
            err_sum    = 0;
            held_drive = 0;
            fail_count = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function void write_register(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_PROPORTIONAL_GAIN: kp = data;
                CFG_INTEGRAL_GAIN:     ki = data;
                CFG_DERIVATIVE_GAIN:   kd = data;
                CFG_SAMPLE_PERIOD_MS:  period = data[15:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_pid_in item);
            logic [31:0] elapsed;
            longint      err;
            longint      sum;
            longint      diff;
            longint      acc;
            t_pid_out    want;
            elapsed = item.time_ms - last_time;
            want.updated = !primed || (elapsed >= {16'd0, period});
            if (want.updated) begin
                err  = longint'(item.setpoint) - longint'(item.measurement);
                sum  = clamp32(err_sum + err);
                diff = err - prev_err;
                acc  = longint'(kp) * err + longint'(kd) * diff + longint'(ki) * sum;
                // Arithmetic shift of a signed value rounds toward minus infinity.
                held_drive = clamp32(acc >>> 16);
                prev_err   = err;
                err_sum    = sum;
                last_time  = item.time_ms;
                primed     = 1'b1;
            end
            want.drive = held_drive[31:0];
            pending_drives.push_back(want);
        endfunction

        function void check_drive(t_pid_out got);
            t_pid_out want;
            if (pending_drives.size() == 0) begin
                $error("result with no item waiting: updated=%0d drive=%0d",
                       got.updated, got.drive);
                fail_count++;
                return;
            end
            want = pending_drives.pop_front();
            if (got.updated !== want.updated) begin
                $error("updated: expected %0d, actual %0d", want.updated, got.updated);
                fail_count++;
            end
            if (got.drive !== want.drive) begin
                $error("drive: expected %0d, actual %0d", want.drive, got.drive);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return pending_drives.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        cfg_we   = 1'b0;
    t_cfg_idx    cfg_idx  = CFG_PROPORTIONAL_GAIN;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_pid_in     in_data  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_pid_out    out_data;

    pid_drive_checker predictor = new();
    int unsigned      cycle_count = 0;
    bit               steady = 1'b0;
    bit               hold_request = 1'b0;
    logic [31:0]      now_ms = '0;
    logic [15:0]      cur_period = SAMPLE_PERIOD_RESET;

    sampled_pid_controller u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_gain();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 32'd0;
        if (r < 25) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if (r < 80) return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
        return $urandom;
    endfunction

    function automatic t_pid_in sample_at(logic [31:0] t, logic [15:0] sp, logic [15:0] ms);
        t_pid_in s;
        s.time_ms     = t;
        s.setpoint    = sp;
        s.measurement = ms;
        return s;
    endfunction

    // Advances the running time stamp: mostly around one sample period, with
    // occasional wild jumps and steps backwards.
    function automatic t_pid_in next_sample();
        int unsigned r;
        logic [31:0] step;
        t_pid_in     s;
        r = $urandom_range(0, 99);
        if (r < 45) step = cur_period + $urandom_range(0, 3);
        else if (r < 70) step = (cur_period > 1) ? $urandom_range(0, cur_period - 1) : 0;
        else if (r < 85) step = $urandom_range(0, 2 * cur_period + 1);
        else if (r < 93) step = $urandom;
        else step = -$urandom_range(1, 1000);
        now_ms = now_ms + step;
        s.time_ms = now_ms;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            s.setpoint    = CORNERS[$urandom_range(0, 3)];
            s.measurement = CORNERS[$urandom_range(0, 3)];
        end else if (r < 55) begin
            s.setpoint    = 16'($urandom);
            s.measurement = s.setpoint + 16'($urandom_range(0, 64)) - 16'd32;
        end else begin
            s.setpoint    = 16'($urandom);
            s.measurement = 16'($urandom);
        end
        return s;
    endfunction

    // Leaves the write enable high so back-to-back writes need no toggle.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        predictor.write_register(idx, data);
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                                 input logic [31:0] kd, input logic [15:0] period);
        write_reg(CFG_PROPORTIONAL_GAIN, kp);
        write_reg(CFG_INTEGRAL_GAIN, ki);
        write_reg(CFG_DERIVATIVE_GAIN, kd);
        write_reg(CFG_SAMPLE_PERIOD_MS, {16'd0, period});
        cfg_we     <= 1'b0;
        cur_period  = period;
    endtask

    // Valid is left high after acceptance so that a following item with no
    // gap does not toggle it; settle() lowers it when the sender goes quiet.
    task automatic send_item(input t_pid_in item);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predictor.note_sample(item);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) predictor.check_drive(out_data);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] period;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Gate behavior: first item, short and exact periods, wrap, time
        // going backwards, and the sample extremes.
        load_settings(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 16'd10);
        send_item(sample_at(32'h0000_0003, 16'd100, 16'd40));
        send_item(sample_at(32'h0000_0008, 16'd200, 16'd40));
        send_item(sample_at(32'h0000_000D, 16'd200, 16'd40));
        send_item(sample_at(32'hFFFF_FFF0, 16'd50, 16'd70));
        send_item(sample_at(32'hFFFF_FFF9, 16'd50, 16'd70));
        send_item(sample_at(32'h0000_0004, 16'h7FFF, 16'h8000));
        send_item(sample_at(32'h0000_000E, 16'h8000, 16'h7FFF));
        send_item(sample_at(32'h0000_0018, 16'h0000, 16'h0000));
        send_item(sample_at(32'h0000_0022, 16'hFFFF, 16'h0000));
        send_item(sample_at(32'h0000_002C, 16'h0000, 16'h0001));
        settle();

        // Tiny gain so that the shift rounds negative values down.
        load_settings(32'h0000_0001, 32'd0, 32'd0, 16'd1);
        send_item(sample_at(32'h0000_0100, 16'hFFFF, 16'h0000));
        send_item(sample_at(32'h0000_0101, 16'h0001, 16'h0000));
        send_item(sample_at(32'h0000_0102, 16'h8000, 16'h7FFF));
        send_item(sample_at(32'h0000_0103, 16'h7FFF, 16'h8000));
        send_item(sample_at(32'h0000_0103, 16'h7FFF, 16'h8000));
        settle();

        // Drive saturation in both directions with the longest period.
        load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(sample_at(32'h0000_0000, 16'h7FFF, 16'h8000));
        send_item(sample_at(32'h0000_FFFF, 16'h8000, 16'h7FFF));
        send_item(sample_at(32'h0001_FFFD, 16'h0000, 16'h0000));
        settle();

        // A zero period lets every item update, even with equal time stamps.
        load_settings(32'h8000_0000, 32'd0, 32'h8000_0000, 16'd0);
        send_item(sample_at(32'h0000_0005, 16'h7FFF, 16'h8000));
        send_item(sample_at(32'h0000_0005, 16'h8000, 16'h7FFF));
        send_item(sample_at(32'h0000_0005, 16'h0000, 16'h0000));
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: period = 16'd1;
                1: period = 16'($urandom_range(2, 20));
                2: period = 16'd10;
                3: period = 16'($urandom_range(1, 100));
                4: period = 16'hFFFF;
                5: period = 16'($urandom_range(1, 30));
                6: period = 16'd0;
                default: period = 16'($urandom_range(1, 65535));
            endcase
            load_settings(pick_gain(), pick_gain(), pick_gain(), period);
            steady = (ph == 3);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // The output side stalls long enough for the input to back up.
                if (ph == 2 && k == 20) hold_request = 1'b1;
                if (ph == 5 && k == 35) settle();
                send_item(next_sample());
            end
            settle();
        end
        steady = 1'b0;

        if (predictor.fail_count == 0 && predictor.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
